// ===== design/collinear_point_filter_core_defines.svh =====
// ---------------------------------------------------------------------------
// collinear_point_filter_core_defines.svh
// Assertion macros shared by the filter's RTL. They expect clk and arst_n
// in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef COLLINEAR_POINT_FILTER_CORE_DEFINES_SVH
`define COLLINEAR_POINT_FILTER_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define CPF_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define CPF_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CPF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/cpf_pkg.sv =====
// ---------------------------------------------------------------------------
// cpf_pkg
// Shared constants and types of the collinear point filter.
// ---------------------------------------------------------------------------
package cpf_pkg;

	localparam int RUN_DEPTH_DEF  = 256;
	localparam int COORD_BITS_DEF = 32;
	localparam int DATA_W         = 32;
	localparam int TOL_W          = 31;
	localparam int APB_AW         = 3;
	localparam int MID_DEPTH      = 2;
	localparam int OUT_DEPTH      = 4;

	// word index of the tolerance register (paddr[2])
	localparam logic REG_TOL = 1'b0;

	typedef enum logic [1:0] {
		KIND_FIRST  = 2'd0,
		KIND_SECOND = 2'd1,
		KIND_TEST   = 2'd2
	} kind_t;

	typedef struct packed {
		logic start;
	} lck_ctl_t;

	typedef struct packed {
		logic done;
		logic near;
	} lck_sts_t;

endpackage

// ===== design/cpf_fifo.sv =====
// ---------------------------------------------------------------------------
// cpf_fifo
// Small first-in first-out queue with a combinational head.
// ---------------------------------------------------------------------------
module cpf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty,
	output logic             space2
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wr_q;
	logic [AW:0]      rd_q;
	logic [AW:0]      count;

	assign count  = wr_q - rd_q;
	assign full   = (count == (AW+1)'(DEPTH));
	assign empty  = (wr_q == rd_q);
	assign space2 = (count <= (AW+1)'(DEPTH - 2));
	assign rdata  = mem_q[rd_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q[AW-1:0]] <= wdata;
		end
	end

endmodule

// ===== design/cpf_front.sv =====
// ---------------------------------------------------------------------------
// cpf_front
// Accept points, trim them to coordinate width and tag each with its place
// in the path.
// ---------------------------------------------------------------------------
module cpf_front #(
	parameter int CW = cpf_pkg::COORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic signed [cpf_pkg::DATA_W-1:0] pos_x,
	input  logic signed [cpf_pkg::DATA_W-1:0] pos_y,
	input  logic signed [cpf_pkg::DATA_W-1:0] pos_z,
	input  logic                       end_of_path,
	input  logic                       q_full,
	output logic                       q_push,
	output logic [2:0][CW-1:0]         q_point,
	output logic                       q_last,
	output cpf_pkg::kind_t             q_kind
);

	logic [1:0] seen_q;

	assign q_push  = push && !q_full;
	assign q_point = {pos_z[CW-1:0], pos_y[CW-1:0], pos_x[CW-1:0]};
	assign q_last  = end_of_path;

	always_comb begin
		case (seen_q)
			2'd0:    q_kind = cpf_pkg::KIND_FIRST;
			2'd1:    q_kind = cpf_pkg::KIND_SECOND;
			default: q_kind = cpf_pkg::KIND_TEST;
		endcase
	end

	// count points of the path, saturate at two, restart after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 2'd0;
		end else if (q_push) begin
			if (end_of_path) begin
				seen_q <= 2'd0;
			end else if (seen_q != 2'd2) begin
				seen_q <= seen_q + 2'd1;
			end
		end
	end

endmodule

// ===== design/cpf_lineck.sv =====
// ---------------------------------------------------------------------------
// cpf_lineck
// Exact line-distance test on one shared multiplier:
// |a x b|^2 - tol^2 * |b|^2, negative means near.
// ---------------------------------------------------------------------------
module cpf_lineck #(
	parameter int CW = cpf_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cpf_pkg::lck_ctl_t            ctl,
	input  logic [2:0][CW-1:0]           origin,
	input  logic [2:0][CW-1:0]           mid,
	input  logic [2:0][CW-1:0]           newp,
	input  logic [cpf_pkg::TOL_W-1:0]    tol,
	output cpf_pkg::lck_sts_t            sts
);

	localparam int DW    = CW + 1;
	localparam int L     = DW + 1;
	localparam int TW    = cpf_pkg::TOL_W;
	localparam int OW    = (DW + 2 > TW + 1) ? DW + 2 : TW + 1;
	localparam int PW    = 2 * OW;
	localparam int CRW   = 2 * DW + 1;
	localparam int BBW   = 2 * DW;
	localparam int T2W   = 2 * TW;
	localparam int ACCW  = ((4 * DW > BBW + T2W) ? 4 * DW : BBW + T2W) + 2;
	localparam int NSTEP = 23;
	localparam int SW    = $clog2(NSTEP);

	typedef enum logic [2:0] {
		D_CR_LD, D_CR_SUB, D_BB_LD, D_BB_ADD, D_T2_LD, D_ACC_ADD, D_ACC_SUB
	} dest_t;

	typedef enum logic [2:0] {
		SH_0, SH_L, SH_L1, SH_2L, SH_T, SH_TL
	} shift_t;

	logic signed [DW-1:0]   a_q [3];
	logic signed [DW-1:0]   b_q [3];
	logic signed [CRW-1:0]  cr_q [3];
	logic [TW-1:0]          tol_q;
	logic [BBW-1:0]         bb_q;
	logic [T2W-1:0]         t2_q;
	logic signed [ACCW-1:0] acc_q;

	logic                   run_q;
	logic [SW-1:0]          step_q;
	logic                   vld_s1;
	logic                   last_s1;
	logic                   done_q;
	logic signed [PW-1:0]   prod_s1;
	dest_t                  dest_s1;
	shift_t                 sh_s1;
	logic [1:0]             sel_s1;

	logic signed [OW-1:0]   op_x;
	logic signed [OW-1:0]   op_y;
	dest_t                  dest;
	shift_t                 sh;
	logic [1:0]             sel;
	logic signed [OW-1:0]   lo [3];
	logic signed [OW-1:0]   hi [3];
	logic signed [OW-1:0]   tlo, thi, blo, bhi;
	logic signed [ACCW-1:0] ext;
	logic signed [ACCW-1:0] term;

	// split each cross component into a signed high and an unsigned low half, and tol^2 and |b|^2 into unsigned halves
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lo[k] = OW'($signed({1'b0, cr_q[k][L-1:0]}));
			hi[k] = OW'($signed(cr_q[k][CRW-1:L]));
		end
		tlo = OW'($signed({1'b0, t2_q[TW-1:0]}));
		thi = OW'($signed({1'b0, t2_q[T2W-1:TW]}));
		blo = OW'($signed({1'b0, bb_q[L-1:0]}));
		bhi = OW'($signed({1'b0, bb_q[BBW-1:L]}));
	end

	// product schedule: cross terms, |b|^2, tol^2, squares, then the right side
	always_comb begin
		op_x = '0;
		op_y = '0;
		dest = D_ACC_ADD;
		sh   = SH_0;
		sel  = 2'd0;
		case (step_q)
			0:  begin op_x = OW'(a_q[1]); op_y = OW'(b_q[2]); dest = D_CR_LD;  sel = 2'd0; end
			1:  begin op_x = OW'(a_q[2]); op_y = OW'(b_q[1]); dest = D_CR_SUB; sel = 2'd0; end
			2:  begin op_x = OW'(a_q[2]); op_y = OW'(b_q[0]); dest = D_CR_LD;  sel = 2'd1; end
			3:  begin op_x = OW'(a_q[0]); op_y = OW'(b_q[2]); dest = D_CR_SUB; sel = 2'd1; end
			4:  begin op_x = OW'(a_q[0]); op_y = OW'(b_q[1]); dest = D_CR_LD;  sel = 2'd2; end
			5:  begin op_x = OW'(a_q[1]); op_y = OW'(b_q[0]); dest = D_CR_SUB; sel = 2'd2; end
			6:  begin op_x = OW'(b_q[0]); op_y = OW'(b_q[0]); dest = D_BB_LD;  end
			7:  begin op_x = OW'(b_q[1]); op_y = OW'(b_q[1]); dest = D_BB_ADD; end
			8:  begin op_x = OW'(b_q[2]); op_y = OW'(b_q[2]); dest = D_BB_ADD; end
			9:  begin
				op_x = OW'($signed({1'b0, tol_q}));
				op_y = OW'($signed({1'b0, tol_q}));
				dest = D_T2_LD;
			end
			10: begin op_x = lo[0]; op_y = lo[0]; sh = SH_0;  end
			11: begin op_x = hi[0]; op_y = lo[0]; sh = SH_L1; end
			12: begin op_x = hi[0]; op_y = hi[0]; sh = SH_2L; end
			13: begin op_x = lo[1]; op_y = lo[1]; sh = SH_0;  end
			14: begin op_x = hi[1]; op_y = lo[1]; sh = SH_L1; end
			15: begin op_x = hi[1]; op_y = hi[1]; sh = SH_2L; end
			16: begin op_x = lo[2]; op_y = lo[2]; sh = SH_0;  end
			17: begin op_x = hi[2]; op_y = lo[2]; sh = SH_L1; end
			18: begin op_x = hi[2]; op_y = hi[2]; sh = SH_2L; end
			19: begin op_x = tlo; op_y = blo; dest = D_ACC_SUB; sh = SH_0;  end
			20: begin op_x = tlo; op_y = bhi; dest = D_ACC_SUB; sh = SH_L;  end
			21: begin op_x = thi; op_y = blo; dest = D_ACC_SUB; sh = SH_T;  end
			22: begin op_x = thi; op_y = bhi; dest = D_ACC_SUB; sh = SH_TL; end
			default: begin end
		endcase
	end

	assign ext = ACCW'(prod_s1);

	always_comb begin
		case (sh_s1)
			SH_0:    term = ext;
			SH_L:    term = ext <<< L;
			SH_L1:   term = ext <<< (L + 1);
			SH_2L:   term = ext <<< (2 * L);
			SH_T:    term = ext <<< TW;
			SH_TL:   term = ext <<< (TW + L);
			default: term = ext;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			step_q  <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s1  <= run_q;
			last_s1 <= run_q && (step_q == SW'(NSTEP - 1));
			done_q  <= last_s1;
			if (ctl.start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(NSTEP - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(op_x * op_y);
		dest_s1 <= dest;
		sh_s1   <= sh;
		sel_s1  <= sel;
		if (ctl.start) begin
			for (int i = 0; i < 3; i++) begin
				a_q[i] <= DW'($signed(mid[i]))  - DW'($signed(origin[i]));
				b_q[i] <= DW'($signed(newp[i])) - DW'($signed(origin[i]));
			end
			tol_q <= tol;
			acc_q <= '0;
		end else if (vld_s1) begin
			case (dest_s1)
				D_CR_LD:   cr_q[sel_s1] <= $signed(prod_s1[CRW-1:0]);
				D_CR_SUB:  cr_q[sel_s1] <= cr_q[sel_s1] - $signed(prod_s1[CRW-1:0]);
				D_BB_LD:   bb_q  <= prod_s1[BBW-1:0];
				D_BB_ADD:  bb_q  <= bb_q + prod_s1[BBW-1:0];
				D_T2_LD:   t2_q  <= prod_s1[T2W-1:0];
				D_ACC_ADD: acc_q <= acc_q + term;
				D_ACC_SUB: acc_q <= acc_q - term;
				default:   acc_q <= acc_q;
			endcase
		end
	end

	assign sts.done = done_q;
	assign sts.near = acc_q[ACCW-1];

endmodule

// ===== design/cpf_back.sv =====
// ---------------------------------------------------------------------------
// cpf_back
// Run state, point store and decisions; one tagged point at a time.
// ---------------------------------------------------------------------------
`include "collinear_point_filter_core_defines.svh"

module cpf_back #(
	parameter int RUN_DEPTH = cpf_pkg::RUN_DEPTH_DEF,
	parameter int CW        = cpf_pkg::COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [cpf_pkg::TOL_W-1:0] tol,
	input  logic                      in_empty,
	output logic                      in_pop,
	input  logic [2:0][CW-1:0]        in_point,
	input  logic                      in_last,
	input  cpf_pkg::kind_t            in_kind,
	input  logic                      out_space2,
	input  logic                      out_full,
	output logic                      out_push,
	output logic [2:0][CW-1:0]        out_point,
	output logic                      out_done
);

	localparam int IW = $clog2(RUN_DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_CALC  = 4'b0100,
		ST_EMIT2 = 4'b1000
	} state_t;

	state_t              state_q;
	logic [IW-1:0]       mid_q;
	logic [IW-1:0]       newest_q;
	logic                even_q;
	logic [2:0][CW-1:0]  origin_q;
	logic [2:0][CW-1:0]  good_q;
	logic [2:0][CW-1:0]  pt_q;
	logic                last_q;
	logic [3*CW-1:0]     store_q [RUN_DEPTH];
	logic [3*CW-1:0]     rdata_q;

	logic                start_item;
	logic                ok;
	logic                wr_en;
	logic [IW-1:0]       wr_addr;
	logic [2:0][CW-1:0]  wr_data;
	cpf_pkg::lck_ctl_t   lck_ctl;
	cpf_pkg::lck_sts_t   lck_sts;

	assign start_item = (state_q == ST_IDLE) && !in_empty && out_space2;
	assign in_pop     = start_item;
	assign ok         = lck_sts.near && (newest_q != IW'(RUN_DEPTH - 1));
	assign lck_ctl.start = (state_q == ST_READ);

	cpf_lineck #(.CW(CW)) u_lineck (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lck_ctl),
		.origin (origin_q),
		.mid    (rdata_q),
		.newp   (pt_q),
		.tol    (tol),
		.sts    (lck_sts)
	);

	always_comb begin
		out_push  = 1'b0;
		out_point = pt_q;
		out_done  = 1'b1;
		wr_en     = 1'b0;
		wr_addr   = IW'(1);
		wr_data   = pt_q;
		case (state_q)
			ST_IDLE: begin
				if (start_item) begin
					out_point = in_point;
					out_done  = in_last;
					wr_data   = in_point;
					if (in_kind == cpf_pkg::KIND_FIRST) begin
						out_push = 1'b1;
					end else if (in_kind == cpf_pkg::KIND_SECOND) begin
						out_push = in_last;
						wr_en    = 1'b1;
					end
				end
			end
			ST_CALC: begin
				if (lck_sts.done) begin
					wr_en = 1'b1;
					if (ok) begin
						out_push = last_q;
						wr_addr  = newest_q + 1'b1;
					end else begin
						out_push  = 1'b1;
						out_point = good_q;
						out_done  = 1'b0;
					end
				end
			end
			ST_EMIT2: out_push = 1'b1;
			default: begin end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		rdata_q <= store_q[mid_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mid_q    <= '0;
			newest_q <= '0;
			even_q   <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start_item) begin
						case (in_kind)
							cpf_pkg::KIND_FIRST: begin
								mid_q    <= '0;
								newest_q <= '0;
								if (in_last) begin
									even_q <= 1'b1;
								end
							end
							cpf_pkg::KIND_SECOND: begin
								if (in_last) begin
									mid_q    <= '0;
									newest_q <= '0;
									even_q   <= 1'b1;
								end else begin
									mid_q    <= IW'(1);
									newest_q <= IW'(1);
								end
							end
							default: state_q <= ST_READ;
						endcase
					end
				end
				ST_READ: state_q <= ST_CALC;
				ST_CALC: begin
					if (lck_sts.done) begin
						state_q <= ST_IDLE;
						if (ok && last_q) begin
							mid_q    <= '0;
							newest_q <= '0;
							even_q   <= 1'b1;
						end else if (ok) begin
							newest_q <= newest_q + 1'b1;
							if (even_q) begin
								mid_q <= mid_q + 1'b1;
							end
							even_q <= !even_q;
						end else begin
							mid_q    <= IW'(1);
							newest_q <= IW'(1);
							if (last_q) begin
								state_q <= ST_EMIT2;
							end
						end
					end
				end
				ST_EMIT2: begin
					state_q  <= ST_IDLE;
					mid_q    <= '0;
					newest_q <= '0;
					even_q   <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start_item) begin
			pt_q   <= in_point;
			last_q <= in_last;
			if (in_kind == cpf_pkg::KIND_FIRST) begin
				origin_q <= in_point;
				good_q   <= in_point;
			end else if (in_kind == cpf_pkg::KIND_SECOND) begin
				good_q <= in_point;
			end
		end else if ((state_q == ST_CALC) && lck_sts.done) begin
			good_q <= pt_q;
			if (!ok) begin
				origin_q <= good_q;
			end
		end
	end

	`CPF_ASSERT_ALWAYS(a_mid_le_newest, mid_q <= newest_q, "middle index passed newest index")
	`CPF_ASSERT_IMPLY(a_push_room, out_push, !out_full, "result pushed into a full queue")
	`CPF_ASSERT_IMPLY(a_done_in_calc, lck_sts.done, state_q == ST_CALC, "line test ended outside calc")
	`CPF_ASSERT_NEXT(a_read_to_calc, state_q == ST_READ, state_q == ST_CALC, "read not followed by calc")

endmodule

// ===== design/collinear_point_filter_core.sv =====
// ---------------------------------------------------------------------------
// collinear_point_filter_core
// Drops toolpath points that lie within tolerance of the line from the last
// kept point; passes on the first and final point of each path.
// ---------------------------------------------------------------------------
//
//   channel   handshake            payload
//   -------   ------------------   -----------------------------------------
//   input     push / full          pos_x, pos_y, pos_z, end_of_path
//   result    pop / empty          kept_x, kept_y, kept_z, path_done
//   config    APB (psel..pready)   tolerance at byte address 0
//
// The first and second point of a path are handled from the idle state in the back end.
// Every later point passes the read and calc states: a start, a store read,
// 23 products on the one shared multiplier of the line test and a pipeline drain;
// one that breaks the run at path end also passes the emit state.
// A two-word queue holds tagged points ahead of the back end; a four-word
// queue holds results, and the back end starts an item only with room for
// two results, so a stalled pop stalls the back end and, once the first queue fills, the input.
// Reset clears control state only; the run store needs no clearing.
//
module collinear_point_filter_core #(
	parameter int RUN_DEPTH  = cpf_pkg::RUN_DEPTH_DEF,
	parameter int COORD_BITS = cpf_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [cpf_pkg::APB_AW-1:0]         paddr,
	input  logic [cpf_pkg::DATA_W-1:0]         pwdata,
	output logic [cpf_pkg::DATA_W-1:0]         prdata,
	output logic                               pready,
	// points in
	input  logic                               push,
	output logic                               full,
	input  logic signed [cpf_pkg::DATA_W-1:0]  pos_x,
	input  logic signed [cpf_pkg::DATA_W-1:0]  pos_y,
	input  logic signed [cpf_pkg::DATA_W-1:0]  pos_z,
	input  logic                               end_of_path,
	// kept points out
	output logic                               empty,
	input  logic                               pop,
	output logic signed [cpf_pkg::DATA_W-1:0]  kept_x,
	output logic signed [cpf_pkg::DATA_W-1:0]  kept_y,
	output logic signed [cpf_pkg::DATA_W-1:0]  kept_z,
	output logic                               path_done
);

	localparam int CW    = COORD_BITS;
	localparam int MID_W = 3 + 3 * CW;
	localparam int OUT_W = 1 + 3 * CW;

	logic [cpf_pkg::TOL_W-1:0] tol_q;

	logic                      f_push;
	logic [2:0][CW-1:0]        f_point;
	logic                      f_last;
	cpf_pkg::kind_t            f_kind;
	logic [MID_W-1:0]          mid_rdata;
	logic                      mid_empty;
	logic                      mid_pop;

	logic                      b_push;
	logic [2:0][CW-1:0]        b_point;
	logic                      b_done;
	logic [OUT_W-1:0]          out_rdata;
	logic                      out_full;
	logic                      out_space2;
	logic                      mid_space2;

	// register file: one word, decoded on the word bit of the address
	assign pready = 1'b1;
	assign prdata = (paddr[2] == cpf_pkg::REG_TOL) ?
		cpf_pkg::DATA_W'(tol_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (psel && penable && pwrite && pready &&
			(paddr[2] == cpf_pkg::REG_TOL)) begin
			tol_q <= pwdata[cpf_pkg::TOL_W-1:0];
		end
	end

	// front: tag each point as first, second or tested
	cpf_front #(.CW(CW)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.end_of_path (end_of_path),
		.q_full      (full),
		.q_push      (f_push),
		.q_point     (f_point),
		.q_last      (f_last),
		.q_kind      (f_kind)
	);

	// hold tagged points between front and back
	cpf_fifo #(.WIDTH(MID_W), .DEPTH(cpf_pkg::MID_DEPTH)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  ({f_kind, f_last, f_point}),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.full   (full),
		.empty  (mid_empty),
		.space2 (mid_space2)
	);

	// back: run state, store and line test
	cpf_back #(.RUN_DEPTH(RUN_DEPTH), .CW(CW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tol        (tol_q),
		.in_empty   (mid_empty),
		.in_pop     (mid_pop),
		.in_point   (mid_rdata[3*CW-1:0]),
		.in_last    (mid_rdata[3*CW]),
		.in_kind    (cpf_pkg::kind_t'(mid_rdata[MID_W-1:3*CW+1])),
		.out_space2 (out_space2),
		.out_full   (out_full),
		.out_push   (b_push),
		.out_point  (b_point),
		.out_done   (b_done)
	);

	// hold kept points until popped
	cpf_fifo #(.WIDTH(OUT_W), .DEPTH(cpf_pkg::OUT_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (b_push),
		.wdata  ({b_done, b_point}),
		.pop    (pop),
		.rdata  (out_rdata),
		.full   (out_full),
		.empty  (empty),
		.space2 (out_space2)
	);

	// sign-extend kept coordinates to the port width
	assign kept_x    = cpf_pkg::DATA_W'($signed(out_rdata[CW-1:0]));
	assign kept_y    = cpf_pkg::DATA_W'($signed(out_rdata[2*CW-1:CW]));
	assign kept_z    = cpf_pkg::DATA_W'($signed(out_rdata[3*CW-1:2*CW]));
	assign path_done = out_rdata[3*CW];

endmodule

// ===== tb/sv/collinear_point_filter_core_tb.sv =====
// ---------------------------------------------------------------------------
// collinear_point_filter_core_tb
// Streams 3-D toolpath points through the filter and checks every kept
// point against a built-in predictor of the collinear point reduction.
// ---------------------------------------------------------------------------
module collinear_point_filter_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH     = cpf_pkg::RUN_DEPTH_DEF;
	localparam int LIMIT_CYC = 2000000;
	localparam int SETTLE    = 80;
	localparam int HOLD_CYC  = 2000;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} pt_t;

	typedef struct packed {
		pt_t  p;
		logic last;
	} word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [cpf_pkg::APB_AW-1:0] paddr = '0;
	logic [cpf_pkg::DATA_W-1:0] pwdata = '0;
	logic [cpf_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic push = 1'b0;
	logic full;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic end_of_path = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic signed [31:0] kept_x, kept_y, kept_z;
	logic path_done;

	collinear_point_filter_core DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	pt_t         run_pts [DEPTH];
	pt_t         org_pt, good_pt;
	int unsigned mid_idx, new_idx, seen;
	bit          even;
	logic [30:0] tol;

	word_t pending_pts[$];
	word_t kept_pts[$];

	int errors = 0;
	int n_sent = 0, n_kept = 0, n_fail_breaks = 0;
	int send_idle = 9, recv_idle = 80;
	bit recv_hold = 1'b0;
	bit hold_start = 1'b0, hold_done = 1'b0;
	longint cycles = 0;

	task automatic report(input string what, input word_t got, input word_t want);
		$display("MISMATCH %s: got %h_%h_%h/%b want %h_%h_%h/%b", what,
			got.p.x, got.p.y, got.p.z, got.last, want.p.x, want.p.y, want.p.z, want.last);
		errors++;
	endtask

	task automatic put_pending(input word_t w);
		pending_pts.insert(pending_pts.size(), w);
	endtask

	task automatic put_kept(input word_t w);
		kept_pts.insert(kept_pts.size(), w);
	endtask

	function automatic bit near_line(pt_t o, pt_t m, pt_t n);
		logic signed [33:0]  a [3];
		logic signed [33:0]  b [3];
		logic signed [68:0]  c [3];
		logic        [159:0] lhs, bb, rhs;
		a[0] = 34'(m.x) - 34'(o.x); b[0] = 34'(n.x) - 34'(o.x);
		a[1] = 34'(m.y) - 34'(o.y); b[1] = 34'(n.y) - 34'(o.y);
		a[2] = 34'(m.z) - 34'(o.z); b[2] = 34'(n.z) - 34'(o.z);
		c[0] = 69'(a[1]) * 69'(b[2]) - 69'(a[2]) * 69'(b[1]);
		c[1] = 69'(a[2]) * 69'(b[0]) - 69'(a[0]) * 69'(b[2]);
		c[2] = 69'(a[0]) * 69'(b[1]) - 69'(a[1]) * 69'(b[0]);
		lhs = 0; bb = 0;
		for (int i = 0; i < 3; i++) begin
			lhs += 160'($signed(160'(signed'(c[i]))) * $signed(160'(signed'(c[i]))));
			bb  += 160'($signed(160'(signed'(b[i]))) * $signed(160'(signed'(b[i]))));
		end
		rhs = 160'(tol) * 160'(tol) * bb;
		return lhs < rhs;
	endfunction

	// work out the kept points one accepted word causes
	task automatic predict_kept(input word_t w);
		bit ok;
		if (seen == 0) begin
			org_pt = w.p; run_pts[0] = w.p; good_pt = w.p;
			mid_idx = 0; new_idx = 0; seen = 1;
			put_kept('{w.p, w.last});
			if (w.last) begin seen = 0; even = 1; mid_idx = 0; new_idx = 0; end
			return;
		end
		if (seen == 1) begin
			run_pts[1] = w.p; mid_idx = 1; new_idx = 1; good_pt = w.p; seen = 2;
		end else begin
			ok = near_line(org_pt, run_pts[mid_idx], w.p) && (new_idx + 1 < DEPTH);
			if (ok) begin
				new_idx++;
				run_pts[new_idx] = w.p;
				good_pt = w.p;
				if (even) mid_idx++;
				even = !even;
			end else begin
				put_kept('{good_pt, 1'b0});
				n_fail_breaks++;
				org_pt = good_pt; run_pts[0] = good_pt; run_pts[1] = w.p;
				mid_idx = 1; new_idx = 1; good_pt = w.p;
			end
		end
		if (w.last) begin
			put_kept('{w.p, 1'b1});
			seen = 0; even = 1; mid_idx = 0; new_idx = 0;
		end
	endtask

	// driver: offer the head of the pending queue, hold it until taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				predict_kept('{'{pos_x, pos_y, pos_z}, end_of_path});
				void'(pending_pts.pop_front());
				n_sent++;
			end
			if (!(push && full)) begin
				if (pending_pts.size() > 0 && $urandom_range(99) >= send_idle) begin
					push <= 1'b1;
					{pos_x, pos_y, pos_z, end_of_path} <= pending_pts[0];
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: check each popped word against the oldest expectation
	always @(posedge clk) begin
		word_t got, want;
		cycles++;
		if (arst_n) begin
			if (pop && !empty) begin
				got = '{'{kept_x, kept_y, kept_z}, path_done};
				n_kept++;
				if (kept_pts.size() == 0) begin
					report("unexpected word", got, got);
				end else begin
					want = kept_pts.pop_front();
					if (got.p.x !== want.p.x) report("kept_x", got, want);
					if (got.p.y !== want.p.y) report("kept_y", got, want);
					if (got.p.z !== want.p.z) report("kept_z", got, want);
					if (got.last !== want.last) report("path_done", got, want);
				end
			end
			pop <= !recv_hold && ($urandom_range(99) >= recv_idle);
		end
		if (cycles > LIMIT_CYC) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// long receiver hold, counted here once requested
	initial begin
		wait (hold_start);
		recv_hold <= 1'b1;
		for (int c = 0; c < HOLD_CYC; c++) @(posedge clk);
		recv_hold <= 1'b0;
		hold_done = 1'b1;
	end

	task automatic apb_write(input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		tol = val[30:0];
	endtask

	// hold until every queued word is taken and every kept point has arrived
	task automatic drain();
		while (pending_pts.size() > 0 || push || kept_pts.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_coord(input int mode);
		case (mode)
			0: return $urandom_range(200) - 100;
			1: return $urandom;
			default: return $urandom_range(4095) << 8;
		endcase
	endfunction

	// a path along a noisy line, so runs grow long before they break
	task automatic queue_path(input int len, input int noise);
		pt_t base, dir, p;
		base = '{rnd_coord(2), rnd_coord(2), rnd_coord(2)};
		dir  = '{int'($urandom_range(512)) - 256, int'($urandom_range(512)) - 256,
			int'($urandom_range(512)) - 256};
		for (int i = 0; i < len; i++) begin
			p.x = base.x + dir.x * i + int'($urandom_range(2 * noise)) - noise;
			p.y = base.y + dir.y * i + int'($urandom_range(2 * noise)) - noise;
			p.z = base.z + dir.z * i + int'($urandom_range(2 * noise)) - noise;
			if ($urandom_range(15) == 0) p = '{$urandom, $urandom, $urandom};
			put_pending('{p, i == len - 1});
		end
	endtask

	initial begin
		int target;
		seen = 0; even = 1; mid_idx = 0; new_idx = 0; tol = '0;
		org_pt = '0; good_pt = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero tolerance, then extremes and every path-end case
		apb_write(0);
		put_pending('{'{32'sh7fffffff, 32'sh80000000, 32'sh0}, 1'b1});
		put_pending('{'{32'sh80000000, 32'sh7fffffff, 32'shffffffff}, 1'b0});
		put_pending('{'{32'sh0, 32'sh0, 32'sh0}, 1'b1});
		put_pending('{'{32'sh0, 32'sh0, 32'sh0}, 1'b0});
		put_pending('{'{32'sh10, 32'sh10, 32'sh10}, 1'b0});
		put_pending('{'{32'sh20, 32'sh20, 32'sh20}, 1'b1});
		drain();
		apb_write(32'h7fffffff);
		// straight line, then a repeat of the origin, then a break at path end
		for (int i = 0; i < 6; i++)
			put_pending('{'{32'(i * 100), 32'(i * 50), 32'sh0}, 1'b0});
		put_pending('{'{32'sh0, 32'sh0, 32'sh0}, 1'b0});
		put_pending('{'{32'sh80000000, 32'sh80000000, 32'sh7fffffff}, 1'b0});
		put_pending('{'{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000}, 1'b1});
		drain();

		// long run that fills the store and is forced to break
		apb_write(32'h00010000);
		for (int i = 0; i < DEPTH + 4; i++)
			put_pending('{'{32'(i * 64), 32'sh0, 32'sh0}, i == DEPTH + 3});
		drain();

		// receiver holds off for a long stretch while the sender keeps offering;
		// zero tolerance makes every tested point a kept point
		apb_write(0);
		hold_start = 1'b1;
		queue_path(40, 8);
		wait (hold_done);
		drain();

		// random phases, changing tolerance and idling pattern
		target = n_sent + 700;
		for (int ph = 0; n_sent < target || ph < 6; ph++) begin
			if (ph == 2) begin send_idle = 80; recv_idle = 9; end
			if (ph == 4) begin send_idle = 0;  recv_idle = 0; end
			case (ph % 4)
				0: apb_write($urandom_range(32'h7fffffff));
				1: apb_write($urandom_range(4096));
				2: apb_write(0);
				default: apb_write(32'h7fffffff);
			endcase
			for (int k = 0; k < 8; k++) begin
				if ($urandom_range(4) == 0) begin
					for (int j = 0; j < 6; j++)
						put_pending('{'{rnd_coord(j % 3), rnd_coord(1),
							rnd_coord(0)}, $urandom_range(3) == 0});
				end else begin
					queue_path($urandom_range(1, 30), $urandom_range(0, 64));
				end
			end
			drain();
		end

		$display("covered %0d points, %0d kept points, %0d run breaks on failure",
			n_sent, n_kept, n_fail_breaks);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
